// ----- hw/rtl/timestamped_fragment_reassembler_top_macros.svh -----
// Assertion macros for the timestamped fragment reassembler.
`ifndef TIMESTAMPED_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH
`define TIMESTAMPED_FRAGMENT_REASSEMBLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TFR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("reassembler check failed");
`define TFR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("reassembler sequence check failed");
`else
`define TFR_ASSERT_IMP(lbl, ante, cons)
`define TFR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/tfr_pkg.sv -----
// Types, constants and helpers shared by the fragment reassembler modules.
`timescale 1ns / 1ps
package tfr_pkg;

	localparam int OC_W     = 10;
	localparam int STAMP_W  = 24;
	localparam int SLOT_W   = 3;
	localparam int CNT_W    = 4;
	localparam int CYCLE_W  = 64;
	localparam int LO_W     = 64;
	localparam int HI_W     = 32;
	localparam int VB_W     = 7;
	localparam int SLOT_BITS = 96;
	localparam int SLOT_CNT = 8;
	localparam logic [OC_W-1:0] OC_RESET = 10'd768;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [SLOT_W-1:0]  slot;
		logic [LO_W-1:0]    section_low;
		logic [HI_W-1:0]    section_high;
	} frag_t;

	typedef struct packed {
		logic [CYCLE_W-1:0] cycle_count;
		logic [SLOT_W-1:0]  slot_out;
		logic [LO_W-1:0]    bits_low;
		logic [HI_W-1:0]    bits_high;
		logic [VB_W-1:0]    valid_bits;
		logic               last;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic complete;
		logic last_k;
		logic out_free;
	} status_t;

	// Number of slots covering oc bits, limited to cap.
	function automatic logic [CNT_W-1:0] slots_for(input logic [OC_W-1:0] oc,
		input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < SLOT_CNT; i++) begin
			if (oc > OC_W'(i * SLOT_BITS)) begin
				n = n + CNT_W'(1);
			end
		end
		if (n > cap) begin
			n = cap;
		end
		return n;
	endfunction

endpackage

// ----- hw/rtl/tfr_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module tfr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/tfr_ctrl.sv -----
// Controller: intake of fragments and sequencing of the result burst.
`timescale 1ns / 1ps
module tfr_ctrl import tfr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    frag_valid,
	output logic    frag_stall,
	input  status_t st,
	output cmd_t    cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		frag_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				frag_stall = 1'b0;
				if (frag_valid) begin
					cmd.accept = 1'b1;
					if (st.complete) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				// fetch the stored slot for the next result
				cmd.rd_en = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				// hold until the output register can take the result
				if (st.out_free) begin
					cmd.load = 1'b1;
					state_d  = st.last_k ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/tfr_dp.sv -----
// Datapath: set tracking, cycle extension, slot store and result masking.
`timescale 1ns / 1ps
module tfr_dp import tfr_pkg::*; #(
	parameter int MAX_SLOTS  = 8,
	parameter int STAMP_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [OC_W-1:0] cfg_data,
	input  frag_t           frag,
	input  logic            res_stall,
	output logic            res_valid,
	output res_t            res,
	input  cmd_t            cmd,
	output status_t         st
);

	localparam int AW      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int UPPER_W = CYCLE_W - STAMP_BITS;

	logic [OC_W-1:0]       oc_q;
	logic [MAX_SLOTS-1:0]  mask_q;
	logic [CNT_W-1:0]      count_q;
	logic [CYCLE_W-1:0]    ext_q;
	logic [SLOT_W-1:0]     k_q;
	logic                  res_valid_q;
	res_t                  res_q;

	logic [CNT_W-1:0]      need;
	logic [STAMP_BITS-1:0] stamp_w;
	logic [STAMP_BITS-1:0] low_now;
	logic [UPPER_W-1:0]    upper_n;
	logic [MAX_SLOTS-1:0]  slot_bit;
	logic [MAX_SLOTS-1:0]  mask_n;
	logic [CNT_W-1:0]      count_n;
	logic                  in_range;
	logic                  new_set;
	logic                  dup;
	logic                  keep;
	logic                  done;
	logic                  take;
	logic [LO_W+HI_W-1:0]  rdata;
	logic [OC_W-1:0]       base;
	logic [OC_W-1:0]       diff;
	logic [VB_W-1:0]       vbits;
	logic [LO_W-1:0]       lo_mask;
	logic [HI_W-1:0]       hi_mask;
	logic                  last_k;

	// intake checks
	always_comb begin
		need     = slots_for(oc_q, CNT_W'(MAX_SLOTS));
		stamp_w  = STAMP_BITS'(frag.stamp);
		low_now  = ext_q[STAMP_BITS-1:0];
		in_range = {1'b0, frag.slot} < need;
		new_set  = (count_q != '0) && (low_now != stamp_w);
		slot_bit = MAX_SLOTS'(1) << frag.slot;
		dup      = !new_set && ((mask_q & slot_bit) != '0);
		keep     = in_range && !dup;
		mask_n   = (new_set ? '0 : mask_q) | slot_bit;
		count_n  = (new_set ? '0 : count_q) + CNT_W'(1);
		done     = keep && (count_n >= need);
		take     = cmd.accept && keep;
		// stamp going backwards means the counter wrapped
		upper_n  = ext_q[CYCLE_W-1:STAMP_BITS] + UPPER_W'(stamp_w < low_now);
	end

	// result masking for slot k
	always_comb begin
		base  = (OC_W'(k_q) << 6) + (OC_W'(k_q) << 5);
		diff  = oc_q - base;
		if (oc_q <= base) begin
			vbits = '0;
		end else if (diff >= OC_W'(SLOT_BITS)) begin
			vbits = VB_W'(SLOT_BITS);
		end else begin
			vbits = diff[VB_W-1:0];
		end
		if (vbits >= VB_W'(LO_W)) begin
			lo_mask = '1;
		end else begin
			lo_mask = (LO_W'(1) << vbits[5:0]) - LO_W'(1);
		end
		if (vbits >= VB_W'(SLOT_BITS)) begin
			hi_mask = '1;
		end else if (vbits > VB_W'(LO_W)) begin
			hi_mask = (HI_W'(1) << vbits[4:0]) - HI_W'(1);
		end else begin
			hi_mask = '0;
		end
		last_k = ({1'b0, k_q} + CNT_W'(1)) == need;
	end

	tfr_ram #(
		.WIDTH(LO_W + HI_W),
		.DEPTH(MAX_SLOTS)
	) u_store (
		.clk  (clk),
		.we   (take),
		.waddr(frag.slot[AW-1:0]),
		.wdata({frag.section_high, frag.section_low}),
		.re   (cmd.rd_en),
		.raddr(k_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oc_q        <= OC_RESET;
			mask_q      <= '0;
			count_q     <= '0;
			ext_q       <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				// new size drops any partial set
				oc_q    <= cfg_data;
				mask_q  <= '0;
				count_q <= '0;
			end else if (take) begin
				mask_q  <= done ? '0 : mask_n;
				count_q <= done ? '0 : count_n;
			end
			if (take) begin
				ext_q <= {upper_n, stamp_w};
			end
			if (cmd.load) begin
				k_q         <= last_k ? '0 : k_q + SLOT_W'(1);
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_q.cycle_count <= ext_q;
			res_q.slot_out    <= k_q;
			res_q.bits_low    <= rdata[LO_W-1:0] & lo_mask;
			res_q.bits_high   <= rdata[LO_W+HI_W-1:LO_W] & hi_mask;
			res_q.valid_bits  <= vbits;
			res_q.last        <= last_k;
		end
	end

	assign st.complete = done;
	assign st.last_k   = last_k;
	assign st.out_free = !res_valid_q || !res_stall;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

endmodule

// ----- hw/rtl/timestamped_fragment_reassembler_top.sv -----
// Intake takes one fragment per cycle while a set is being gathered.
// The completing fragment starts a burst: each result passes the READ and LOAD states,
// paced by the slot store's registered read and held while the output is stalled.
// Intake stalls in the burst.
// Reset clears set tracking, the cycle count and the output valid; the size
// register returns to 768 bits. Stored fragments are not cleared.
`timescale 1ns / 1ps
`include "timestamped_fragment_reassembler_top_macros.svh"
module timestamped_fragment_reassembler_top import tfr_pkg::*; #(
	parameter int MAX_SLOTS  = 8,
	parameter int STAMP_BITS = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [OC_W-1:0] cfg_data,
	input  logic            frag_valid,
	output logic            frag_stall,
	input  frag_t           frag,
	output logic            res_valid,
	input  logic            res_stall,
	output res_t            res
);

	cmd_t    cmd;
	status_t st;

	tfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.frag_valid(frag_valid),
		.frag_stall(frag_stall),
		.st        (st),
		.cmd       (cmd)
	);

	tfr_dp #(
		.MAX_SLOTS (MAX_SLOTS),
		.STAMP_BITS(STAMP_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.frag     (frag),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res      (res),
		.cmd      (cmd),
		.st       (st)
	);

	`TFR_ASSERT_NXT(a_done_starts_burst, cmd.accept && st.complete, frag_stall)
	`TFR_ASSERT_IMP(a_load_when_free, cmd.load, st.out_free)
	`TFR_ASSERT_IMP(a_inner_slot_full, res_valid && !res.last, res.valid_bits == VB_W'(SLOT_BITS))

endmodule
